FILE: hdl/hblsm_pkg.sv
// Shared types and constants for the heartbeat liveness and skip monitor.
// No dependencies; hblsm_cfg, hblsm_core and the top level import this package.
package hblsm_pkg;

  localparam int unsigned TimeWidthDef  = 53;
  localparam int unsigned CountWidthDef = 32;
  localparam int unsigned RunWidth      = 8;
  localparam int unsigned PaddrWidth    = 5;
  localparam int unsigned PdataWidth    = 32;

  // Register reset values.
  localparam logic [31:0]         EchoTimeoutRst  = 32'd3000000;
  localparam logic [31:0]         SkipLowRst      = 32'd1000000;
  localparam logic [31:0]         SkipHighRst     = 32'd10000000;
  localparam logic [31:0]         SubTimeoutRst   = 32'd60000000;
  localparam logic [RunWidth-1:0] SkipRunLimitRst = 8'd30;

  typedef enum logic [2:0] {
    FUNC_TICK       = 3'd0,
    FUNC_RESP       = 3'd1,
    FUNC_HB_DONE    = 3'd2,
    FUNC_SUB_CHECK  = 3'd3,
    FUNC_ARM_IGNORE = 3'd4
  } func_e;

  typedef enum logic [2:0] {
    REG_ECHO_TIMEOUT = 3'd0,
    REG_SKIP_LOW     = 3'd1,
    REG_SKIP_HIGH    = 3'd2,
    REG_SUB_TIMEOUT  = 3'd3,
    REG_SKIP_LIMIT   = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic [31:0]         echo_timeout_us;
    logic [31:0]         skip_low_us;
    logic [31:0]         skip_high_us;
    logic [31:0]         subscribe_timeout_us;
    logic [RunWidth-1:0] skip_run_limit;
  } cfg_t;

  typedef struct packed {
    logic tick_ok;
    logic skipped;
    logic provider_disabled;
    logic notify_ready;
    logic topo_ready_out;
    logic subscribe_timed_out;
    logic map_usable;
  } res_t;

endpackage

FILE: hdl/hblsm_evt_if.sv
// Event channel (valid/ready) carrying one heartbeat event per beat.
// Depends on hblsm_pkg for the default time width.
interface hblsm_evt_if #(
  parameter int unsigned TIME_WIDTH = hblsm_pkg::TimeWidthDef
);
  logic                  valid;
  logic                  ready;
  logic [2:0]            func;
  logic [TIME_WIDTH-1:0] now_us;
  logic                  hb_success;
  logic                  send_ok;

  modport source (output valid, func, now_us, hb_success, send_ok, input ready);
  modport sink   (input valid, func, now_us, hb_success, send_ok, output ready);
endinterface

FILE: hdl/hblsm_res_if.sv
// Result channel (valid/ready) carrying one result per beat.
// No dependencies.
interface hblsm_res_if;
  logic valid;
  logic ready;
  logic tick_ok;
  logic skipped;
  logic provider_disabled;
  logic notify_ready;
  logic topo_ready_out;
  logic subscribe_timed_out;
  logic map_usable;

  modport source (output valid, tick_ok, skipped, provider_disabled, notify_ready,
                  topo_ready_out, subscribe_timed_out, map_usable, input ready);
  modport sink   (input valid, tick_ok, skipped, provider_disabled, notify_ready,
                  topo_ready_out, subscribe_timed_out, map_usable, output ready);
endinterface

FILE: hdl/hblsm_cfg.sv
// APB-style configuration register file for the monitor.
// Depends on hblsm_pkg (cfg_t, register indexes, reset values).
module hblsm_cfg (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [hblsm_pkg::PaddrWidth-1:0]   paddr,
  input  logic [hblsm_pkg::PdataWidth-1:0]   pwdata,
  output logic [hblsm_pkg::PdataWidth-1:0]   prdata,
  output logic                               pready,
  output hblsm_pkg::cfg_t                    cfg_o
);
  import hblsm_pkg::*;

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_e'(paddr[PaddrWidth-1:2]);
  assign wr_en  = psel & penable & pwrite & pready;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        REG_ECHO_TIMEOUT: cfg_d.echo_timeout_us      = pwdata;
        REG_SKIP_LOW:     cfg_d.skip_low_us          = pwdata;
        REG_SKIP_HIGH:    cfg_d.skip_high_us         = pwdata;
        REG_SUB_TIMEOUT:  cfg_d.subscribe_timeout_us = pwdata;
        REG_SKIP_LIMIT:   cfg_d.skip_run_limit       = pwdata[RunWidth-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_ECHO_TIMEOUT: prdata = cfg_q.echo_timeout_us;
      REG_SKIP_LOW:     prdata = cfg_q.skip_low_us;
      REG_SKIP_HIGH:    prdata = cfg_q.skip_high_us;
      REG_SUB_TIMEOUT:  prdata = cfg_q.subscribe_timeout_us;
      REG_SKIP_LIMIT:   prdata = {{(PdataWidth-RunWidth){1'b0}}, cfg_q.skip_run_limit};
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.echo_timeout_us      <= EchoTimeoutRst;
      cfg_q.skip_low_us          <= SkipLowRst;
      cfg_q.skip_high_us         <= SkipHighRst;
      cfg_q.subscribe_timeout_us <= SubTimeoutRst;
      cfg_q.skip_run_limit       <= SkipRunLimitRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;
endmodule

FILE: hdl/hblsm_core.sv
// Heartbeat state registers and the single-pass event update logic.
// Depends on hblsm_pkg (func_e, cfg_t, res_t).
module hblsm_core #(
  parameter int unsigned TIME_WIDTH  = hblsm_pkg::TimeWidthDef,
  parameter int unsigned COUNT_WIDTH = hblsm_pkg::CountWidthDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  fire_i,
  input  logic [2:0]            func_i,
  input  logic [TIME_WIDTH-1:0] now_i,
  input  logic                  hb_success_i,
  input  logic                  send_ok_i,
  input  hblsm_pkg::cfg_t       cfg_i,
  output hblsm_pkg::res_t       res_o
);
  import hblsm_pkg::*;

  typedef logic [TIME_WIDTH-1:0] time_t;

  // true when now - then < bound; time running backwards counts as younger
  function automatic logic younger(time_t now, time_t then, logic [31:0] bound);
    time_t age;
    age = now - then;
    return (now < then) || (age < time_t'(bound));
  endfunction

  time_t                  send_q, send_d, echo_q, echo_d, resp_q, resp_d, first_q, first_d;
  logic [COUNT_WIDTH-1:0] total_q, total_d;
  logic [RunWidth-1:0]    run_q, run_d;
  logic [RunWidth:0]      run_inc;
  logic                   es_q, es_d, tr_q, tr_d, sto_q, sto_d, lco_q, lco_d, ign_q, ign_d;
  logic                   to_fire, skip;
  time_t                  send_mid, resp_age;
  func_e                  func;

  assign func     = func_e'(func_i);
  assign run_inc  = {1'b0, run_q} + 1'b1;
  assign resp_age = now_i - resp_q;

  always_comb begin
    send_d  = send_q;
    echo_d  = echo_q;
    resp_d  = resp_q;
    first_d = first_q;
    total_d = total_q;
    run_d   = run_q;
    es_d    = es_q;
    tr_d    = tr_q;
    sto_d   = sto_q;
    lco_d   = lco_q;
    ign_d   = ign_q;
    res_o   = '0;
    to_fire = 1'b0;
    skip    = 1'b0;
    send_mid = send_q;

    unique case (func)
      FUNC_TICK: begin
        // echo timeout check
        to_fire = (send_q != '0) && !younger(now_i, send_q, cfg_i.echo_timeout_us);
        if (to_fire) begin
          lco_d    = es_q && (echo_q >= send_q);
          send_mid = '0;
        end
        res_o.provider_disabled = to_fire && !lco_d;

        // skip decision
        priority if ((total_q == '0) || !lco_d) begin
          skip = 1'b0;
        end else if (ign_q) begin
          ign_d = 1'b0;
        end else if ((echo_q == '0) || !es_q) begin
          run_d = '0;
        end else if (younger(now_i, echo_q, cfg_i.skip_low_us)) begin
          skip = 1'b1;
        end else if ((resp_q == '0) || younger(now_i, resp_q, cfg_i.skip_low_us) ||
                     (resp_age > time_t'(cfg_i.skip_high_us))) begin
          // counted skip: force one send once the run passes the limit
          if (run_inc > {1'b0, cfg_i.skip_run_limit}) begin
            run_d = '0;
          end else begin
            run_d = run_inc[RunWidth-1:0];
            skip  = 1'b1;
          end
        end else begin
          run_d = '0;
        end

        send_d = send_mid;
        if (skip) begin
          res_o.skipped = 1'b1;
          res_o.tick_ok = 1'b1;
        end else begin
          if (total_q == '0) first_d = now_i;
          if (total_q != '1) total_d = total_q + 1'b1;
          if (send_ok_i) begin
            if (send_mid == '0) send_d = now_i;
            res_o.tick_ok = 1'b1;
          end
        end
      end
      FUNC_RESP: begin
        resp_d = now_i;
      end
      FUNC_HB_DONE: begin
        es_d               = hb_success_i;
        res_o.notify_ready = !tr_q;
        tr_d               = 1'b1;
        sto_d              = 1'b0;
        echo_d             = now_i;
      end
      FUNC_SUB_CHECK: begin
        if (tr_q) begin
          res_o.map_usable = 1'b1;
        end else begin
          if (first_q != '0)
            sto_d = (now_i > first_q) &&
                    ((now_i - first_q) > time_t'(cfg_i.subscribe_timeout_us));
          res_o.map_usable = sto_d;
        end
      end
      FUNC_ARM_IGNORE: begin
        ign_d = 1'b1;
      end
      default: ;
    endcase

    res_o.topo_ready_out      = tr_d;
    res_o.subscribe_timed_out = sto_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      send_q  <= '0;
      echo_q  <= '0;
      resp_q  <= '0;
      first_q <= '0;
      total_q <= '0;
      run_q   <= '0;
      es_q    <= 1'b0;
      tr_q    <= 1'b0;
      sto_q   <= 1'b0;
      lco_q   <= 1'b1;
      ign_q   <= 1'b0;
    end else if (fire_i) begin
      send_q  <= send_d;
      echo_q  <= echo_d;
      resp_q  <= resp_d;
      first_q <= first_d;
      total_q <= total_d;
      run_q   <= run_d;
      es_q    <= es_d;
      tr_q    <= tr_d;
      sto_q   <= sto_d;
      lco_q   <= lco_d;
      ign_q   <= ign_d;
    end
  end
endmodule

FILE: hdl/heartbeat_liveness_skip_monitor_unit.sv
// Top level of the heartbeat liveness and skip monitor for one peer host.
// Depends on hblsm_pkg, hblsm_evt_if, hblsm_res_if, hblsm_cfg and hblsm_core.
//
// Usage:
//   evt_i  - event beats (func, now_us, hb_success, send_ok), valid/ready.
//   res_o  - exactly one result beat per event, in event order, valid/ready.
//   APB    - five registers at byte addresses 0,4,8,12,16 (echo timeout, skip low,
//            skip high, subscribe timeout, skip run limit). Write them only while
//            the block holds no event in flight.
// Flow: an event is taken into the input register, runs through the state update
//   logic and lands in the result register once that register is free or draining;
//   res_o.valid then rises and the result waits there until res_o.ready takes it.
// Throughput: one event per cycle while results drain. The heartbeat state is
//   updated in the same cycle that an event moves from the input register to the
//   result register, so back-to-back events see each other's updates with no bubble.
// Stall: when res_o.ready is low the result register holds; an empty input register
//   still takes one more beat, then evt_i.ready drops until the result drains.
// Reset: rst_ni clears the valid flags of both pipeline registers, all heartbeat
//   state (times zero, counts zero, last check ok set), loads register defaults.
module heartbeat_liveness_skip_monitor_unit #(
  parameter int unsigned TIME_WIDTH  = hblsm_pkg::TimeWidthDef,
  parameter int unsigned COUNT_WIDTH = hblsm_pkg::CountWidthDef
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  hblsm_evt_if.sink                        evt_i,
  hblsm_res_if.source                      res_o,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [hblsm_pkg::PaddrWidth-1:0] paddr,
  input  logic [hblsm_pkg::PdataWidth-1:0] pwdata,
  output logic [hblsm_pkg::PdataWidth-1:0] prdata,
  output logic                             pready
);
  import hblsm_pkg::*;

  cfg_t                  cfg;
  res_t                  res_d, res_q;
  logic                  in_vld_q, out_vld_q, fire, in_take;
  logic [2:0]            func_q;
  logic [TIME_WIDTH-1:0] now_q;
  logic                  hb_q, sok_q;

  hblsm_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Advance the held event whenever the result register is free or draining.
  assign fire        = in_vld_q && (!out_vld_q || res_o.ready);
  assign evt_i.ready = !in_vld_q || fire;
  assign in_take     = evt_i.valid && evt_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (evt_i.ready) begin
      in_vld_q <= evt_i.valid;
    end
  end

  // Input payload: no reset needed, qualified by in_vld_q.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      func_q <= evt_i.func;
      now_q  <= evt_i.now_us;
      hb_q   <= evt_i.hb_success;
      sok_q  <= evt_i.send_ok;
    end
  end

  hblsm_core #(
    .TIME_WIDTH  (TIME_WIDTH),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fire_i       (fire),
    .func_i       (func_q),
    .now_i        (now_q),
    .hb_success_i (hb_q),
    .send_ok_i    (sok_q),
    .cfg_i        (cfg),
    .res_o        (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (fire) begin
      out_vld_q <= 1'b1;
    end else if (res_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  // Hold the result while the receiver stalls.
  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q <= res_d;
    end
  end

  assign res_o.valid               = out_vld_q;
  assign res_o.tick_ok             = res_q.tick_ok;
  assign res_o.skipped             = res_q.skipped;
  assign res_o.provider_disabled   = res_q.provider_disabled;
  assign res_o.notify_ready        = res_q.notify_ready;
  assign res_o.topo_ready_out      = res_q.topo_ready_out;
  assign res_o.subscribe_timed_out = res_q.subscribe_timed_out;
  assign res_o.map_usable          = res_q.map_usable;
endmodule

FILE: hdl/hblsm_checker.sv
// Port-level checks for the heartbeat monitor, bound to the top level.
// Depends on heartbeat_liveness_skip_monitor_unit and its interface ports.
module hblsm_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic out_valid,
  input logic out_ready,
  input logic tick_ok,
  input logic skipped,
  input logic notify_ready,
  input logic topo_ready_out,
  input logic subscribe_timed_out,
  input logic map_usable
);

  // A stalled result beat stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  // A skipped tick always reports success.
  a_skip_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && skipped |-> tick_ok)
    else $error("skipped tick without tick_ok");

  // First readiness leaves topology ready and clears the subscribe timeout.
  a_notify: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && notify_ready |-> topo_ready_out && !subscribe_timed_out)
    else $error("notify_ready with inconsistent flags");

  // The map is usable only through readiness or a subscribe timeout.
  a_usable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && map_usable |-> topo_ready_out || subscribe_timed_out)
    else $error("map_usable without ready or timeout");

  // Once a ready result is taken, a result offered directly behind it still shows topology ready.
  a_ready_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_ready && topo_ready_out ##1 out_valid |-> topo_ready_out)
    else $error("topology ready flag fell");

endmodule

bind heartbeat_liveness_skip_monitor_unit hblsm_checker u_hblsm_checker (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .out_valid           (res_o.valid),
  .out_ready           (res_o.ready),
  .tick_ok             (res_o.tick_ok),
  .skipped             (res_o.skipped),
  .notify_ready        (res_o.notify_ready),
  .topo_ready_out      (res_o.topo_ready_out),
  .subscribe_timed_out (res_o.subscribe_timed_out),
  .map_usable          (res_o.map_usable)
);
